[src/glsf_pkg.sv]
// Package for the gap-limited span finder: sizes, opcodes, controller states
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package glsf_pkg;
  localparam int MaxPoints = 1024;
  localparam int Levels = 11;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int LvlW = $clog2(Levels);
  localparam int PosW = 31;

  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StBuild0, StBuildJ, StSrch1, StSrch1Wait, StSrch2, StSrch2Wait,
    StSrch2Eval, StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic do_append;
    logic do_clear;
    logic b0_init;
    logic b0_step;
    logic bj_init;
    logic bj_step;
    logic s1_init;
    logic s1_issue;
    logic s1_eval;
    logic s2_init;
    logic s2_issue;
    logic s2_eval;
    logic done;
  } ctrl_t;

  typedef struct packed {
    logic is_append;
    logic is_query;
    logic is_clear;
    logic table_ok;
    logic b0_last;
    logic bj_all_done;
    logic s1_end;
    logic s1_zero;
    logic s2_end;
  } stat_t;
endpackage
`default_nettype wire

[src/glsf_ctrl.sv]
// Controller for the gap-limited span finder.
// Depends on glsf_pkg.
`default_nettype none
module glsf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire glsf_pkg::stat_t st_i,
  output glsf_pkg::ctrl_t      cmd_o
);
  glsf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= glsf_pkg::StIdle;
    else state_q <= state_d;
  end

  // issue latched in idle; the datapath holds the word
  logic go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) go_q <= 1'b0;
    else go_q <= start_i && (state_q == glsf_pkg::StIdle) && !go_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glsf_pkg::StIdle: begin
        if (go_q && st_i.is_query) begin
          if (st_i.table_ok) state_d = glsf_pkg::StSrch1;
          else state_d = glsf_pkg::StBuild0;
        end
      end
      glsf_pkg::StBuild0: if (st_i.b0_last) state_d = glsf_pkg::StBuildJ;
      glsf_pkg::StBuildJ: if (st_i.bj_all_done) state_d = glsf_pkg::StSrch1;
      glsf_pkg::StSrch1: begin
        if (st_i.s1_end) begin
          if (st_i.s1_zero) state_d = glsf_pkg::StDone;
          else state_d = glsf_pkg::StSrch2;
        end else state_d = glsf_pkg::StSrch1Wait;
      end
      glsf_pkg::StSrch1Wait: state_d = glsf_pkg::StSrch1;
      glsf_pkg::StSrch2: begin
        if (st_i.s2_end) state_d = glsf_pkg::StDone;
        else state_d = glsf_pkg::StSrch2Wait;
      end
      glsf_pkg::StSrch2Wait: state_d = glsf_pkg::StSrch2Eval;
      glsf_pkg::StSrch2Eval: state_d = glsf_pkg::StSrch2;
      glsf_pkg::StDone: state_d = glsf_pkg::StIdle;
      default: state_d = glsf_pkg::StIdle;
    endcase
  end

  logic idle;
  assign idle = state_q == glsf_pkg::StIdle;

  always_comb begin
    cmd_o = '0;
    busy_o = !idle || go_q;
    unique case (state_q)
      glsf_pkg::StIdle: begin
        cmd_o.load = start_i && !go_q;
        if (go_q) begin
          cmd_o.do_append = st_i.is_append;
          cmd_o.do_clear = st_i.is_clear;
          cmd_o.b0_init = st_i.is_query && !st_i.table_ok;
          cmd_o.s1_init = st_i.is_query && st_i.table_ok;
        end
      end
      glsf_pkg::StBuild0: begin
        cmd_o.b0_step = 1'b1;
        cmd_o.bj_init = st_i.b0_last;
      end
      glsf_pkg::StBuildJ: begin
        cmd_o.bj_step = 1'b1;
        cmd_o.s1_init = st_i.bj_all_done;
      end
      glsf_pkg::StSrch1: begin
        cmd_o.s1_issue = !st_i.s1_end;
        cmd_o.s2_init = st_i.s1_end && !st_i.s1_zero;
      end
      glsf_pkg::StSrch1Wait: cmd_o.s1_eval = 1'b1;
      glsf_pkg::StSrch2: cmd_o.s2_issue = !st_i.s2_end;
      glsf_pkg::StSrch2Wait: cmd_o.s2_issue = 1'b1;
      glsf_pkg::StSrch2Eval: cmd_o.s2_eval = 1'b1;
      glsf_pkg::StDone: cmd_o.done = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[src/glsf_dp.sv]
// Datapath for the gap-limited span finder: position memory, sparse table
// memory, search registers. Depends on glsf_pkg.
`default_nettype none
module glsf_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [glsf_pkg::PosW-1:0]   value_i,
  input  wire logic [glsf_pkg::PosW-1:0]   gap_limit_i,
  input  wire glsf_pkg::ctrl_t             cmd_i,
  output glsf_pkg::stat_t                  st_o,
  output logic                             done_o,
  output logic [glsf_pkg::CntW-1:0]        start_index_o
);
  localparam int IdxW = glsf_pkg::IdxW;
  localparam int CntW = glsf_pkg::CntW;
  localparam int LvlW = glsf_pkg::LvlW;
  localparam int PosW = glsf_pkg::PosW;
  localparam int TabW = LvlW + IdxW;

  logic [PosW-1:0] pos_mem [glsf_pkg::MaxPoints];
  logic [PosW-1:0] tab_mem [glsf_pkg::Levels * glsf_pkg::MaxPoints];

  logic [1:0]      op_q;
  logic [PosW-1:0] val_q, lim_q, last_q;
  logic [CntW-1:0] cnt_q;
  logic            tok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      val_q <= value_i;
      lim_q <= gap_limit_i;
    end
  end

  logic app_ok;
  assign app_ok = (cnt_q < CntW'(glsf_pkg::MaxPoints)) &&
                  (cnt_q == '0 || val_q >= last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tok_q <= 1'b0;
    end else if (cmd_i.do_clear) begin
      cnt_q <= '0;
      tok_q <= 1'b0;
    end else if (cmd_i.do_append && app_ok) begin
      cnt_q <= cnt_q + 1'b1;
      tok_q <= 1'b0;
    end else if (cmd_i.s1_init) begin
      tok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_append && app_ok) last_q <= val_q;
  end

  // ---- build state
  logic [CntW-1:0] bi_q;      // level-0 index / level-j index
  logic [LvlW-1:0] bl_q;      // level
  logic [1:0]      bph_q;     // level-j phase: 0 rd a, 1 rd b, 2 write
  logic [PosW-1:0] prev_q, ta_q;

  // ---- search state
  logic [CntW-1:0] lo_q, hi_q, k_q, ans_q;
  logic [CntW:0]   l_q, r_q;  // signed-ish: r may go to l-1
  logic [CntW-1:0] mid_q;
  logic [LvlW-1:0] jq_q;
  logic [1:0]      sph_q;

  // position read port
  logic [IdxW-1:0] pra;
  logic [PosW-1:0] prd_q;
  // table ports
  logic [TabW-1:0] tra, twa;
  logic            twe;
  logic [PosW-1:0] twd, trd_q;

  function automatic logic [TabW-1:0] taddr(logic [LvlW-1:0] l, logic [IdxW-1:0] i);
    return TabW'(l) * TabW'(glsf_pkg::MaxPoints) + TabW'(i);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_append && app_ok) pos_mem[cnt_q[IdxW-1:0]] <= val_q;
    prd_q <= pos_mem[pra];
  end
  always_ff @(posedge clk_i) begin
    if (twe) tab_mem[twa] <= twd;
    trd_q <= tab_mem[tra];
  end

  logic [CntW-1:0] span, half;
  assign span = CntW'(1) << bl_q;
  assign half = span >> 1;

  logic [CntW-1:0] s1_mid;
  assign s1_mid = lo_q + ((hi_q - lo_q) >> 1);
  logic [CntW:0] s2_mid;
  assign s2_mid = l_q + ((r_q - l_q) >> 1);

  // level for a query length len = k-mid+1
  logic [CntW-1:0] qlen;
  logic [LvlW-1:0] qlvl;
  assign qlen = k_q - s2_mid[CntW-1:0] + 1'b1;
  always_comb begin
    qlvl = '0;
    for (int b = 0; b < CntW; b++) if (qlen[b]) qlvl = LvlW'(b);
    if (qlvl > LvlW'(glsf_pkg::Levels - 1)) qlvl = LvlW'(glsf_pkg::Levels - 1);
  end

  always_comb begin
    pra = bi_q[IdxW-1:0];
    tra = '0;
    twa = '0;
    twe = 1'b0;
    twd = '0;
    if (cmd_i.s1_issue) pra = s1_mid[IdxW-1:0];
    if (cmd_i.b0_step && bph_q == 2'd1) begin
      twe = 1'b1;
      twa = taddr('0, bi_q[IdxW-1:0]);
      twd = (bi_q == '0) ? '0 : prd_q - prev_q;
    end
    if (cmd_i.bj_step) begin
      unique case (bph_q)
        2'd0: tra = taddr(bl_q - 1'b1, bi_q[IdxW-1:0]);
        2'd1: tra = taddr(bl_q - 1'b1, IdxW'(bi_q + half));
        default: begin
          twe = 1'b1;
          twa = taddr(bl_q, bi_q[IdxW-1:0]);
          twd = (ta_q > trd_q) ? ta_q : trd_q;
        end
      endcase
    end
    if (cmd_i.s2_issue) begin
      if (sph_q == 2'd0) tra = taddr(qlvl, s2_mid[IdxW-1:0]);
      else tra = taddr(jq_q, IdxW'(k_q + 1'b1 - (CntW'(1) << jq_q)));
    end
  end

  always_ff @(posedge clk_i) begin
    // level 0: phase0 read pos[i], phase1 write gap
    // level j: phase0 read a, phase1 read b and latch a, phase2 write max
    if (cmd_i.bj_init) begin
      bi_q <= '0;
      bl_q <= LvlW'(1);
      bph_q <= '0;
    end else if (cmd_i.b0_init) begin
      bi_q <= '0;
      bph_q <= '0;
    end else if (cmd_i.b0_step) begin
      if (bph_q == 2'd0) bph_q <= 2'd1;
      else begin
        bph_q <= 2'd0;
        prev_q <= prd_q;
        bi_q <= bi_q + 1'b1;
      end
    end else if (cmd_i.bj_step) begin
      if (bi_q + span > cnt_q) begin
        bl_q <= bl_q + 1'b1;
        bi_q <= '0;
        bph_q <= '0;
      end else begin
        case (bph_q)
          2'd0: bph_q <= 2'd1;
          2'd1: begin
            ta_q <= trd_q;
            bph_q <= 2'd2;
          end
          default: begin
            bph_q <= 2'd0;
            bi_q <= bi_q + 1'b1;
          end
        endcase
      end
    end
    // search over positions
    if (cmd_i.s1_init) begin
      lo_q <= '0;
      hi_q <= cnt_q;
    end else if (cmd_i.s1_issue) begin
      mid_q <= s1_mid;
    end else if (cmd_i.s1_eval) begin
      if (prd_q <= val_q) lo_q <= mid_q + 1'b1;
      else hi_q <= mid_q;
    end
    // search over gaps: issue a, issue b while latching a, compare
    if (cmd_i.s2_init) begin
      k_q <= lo_q - 1'b1;
      ans_q <= lo_q;
      l_q <= (CntW+1)'(1);
      r_q <= {1'b0, lo_q - 1'b1};
      sph_q <= '0;
    end else if (cmd_i.s2_issue) begin
      if (sph_q == 2'd0) begin
        jq_q <= qlvl;
        mid_q <= s2_mid[CntW-1:0];
        sph_q <= 2'd1;
      end else begin
        ta_q <= trd_q;
        sph_q <= 2'd2;
      end
    end else if (cmd_i.s2_eval) begin
      sph_q <= '0;
      if (((ta_q > trd_q) ? ta_q : trd_q) > lim_q) l_q <= {1'b0, mid_q} + 1'b1;
      else begin
        ans_q <= mid_q;
        r_q <= {1'b0, mid_q} - 1'b1;
      end
    end
  end

  logic s2_end;
  assign s2_end = (sph_q == 2'd0) && (l_q > r_q || r_q == '0);

  always_comb begin
    st_o.is_append = op_q == glsf_pkg::OpAppend;
    st_o.is_query = op_q == glsf_pkg::OpQuery;
    st_o.is_clear = op_q == glsf_pkg::OpClear;
    st_o.table_ok = tok_q;
    st_o.b0_last = (bph_q == 2'd1 && bi_q + 1'b1 >= cnt_q) || cnt_q == '0;
    st_o.bj_all_done = bl_q >= LvlW'(glsf_pkg::Levels) ||
                       (bl_q == LvlW'(glsf_pkg::Levels - 1) && bi_q + span > cnt_q);
    st_o.s1_end = lo_q >= hi_q;
    st_o.s1_zero = lo_q == '0;
    st_o.s2_end = s2_end;
  end

  assign done_o = cmd_i.done;
  assign start_index_o = (lo_q == '0) ? '0 : ans_q;
endmodule
`default_nettype wire

[src/gap_limited_span_finder.sv]
// Top level of the gap-limited span finder: controller plus datapath.
// Depends on glsf_pkg, glsf_ctrl and glsf_dp.
//
// Usage: present opcode_i, value_i and gap_limit_i with start_i high while
// busy_o is low; the word is taken at that edge. Append (0) and clear (2)
// hold busy_o for one cycle, after which the next word can be taken; they
// give no result. Query (1) gives one result word on start_index_o with
// valid_o high for exactly one cycle.
// A query after a change first rebuilds the sparse table: on level 0 each
// point is read and its gap to the previous point written, then on each
// higher level each entry reads two entries of the level below and writes
// their maximum.
// With a current table the strobe follows p position probes (at most 11)
// and, unless no position is at or below the time, s gap-search steps (at
// most 10), each step waiting on the registered memory reads.
// busy_o drops in the cycle after the strobe.
// Reset clears the point count and marks the table stale; the memories
// are not cleared. The receiver cannot stall: results must be taken in
// the strobe cycle. Opcode 3 is ignored.
`default_nettype none
module gap_limited_span_finder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [glsf_pkg::PosW-1:0]         value_i,
  input  wire logic [glsf_pkg::PosW-1:0]         gap_limit_i,
  output logic                                   valid_o,
  output logic [glsf_pkg::CntW-1:0]              start_index_o
);
  glsf_pkg::ctrl_t cmd;
  glsf_pkg::stat_t st;
  logic done;

  glsf_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .st_i(st), .cmd_o(cmd)
  );

  glsf_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .opcode_i(opcode_i), .value_i(value_i),
    .gap_limit_i(gap_limit_i), .cmd_i(cmd), .st_o(st), .done_o(done),
    .start_index_o(start_index_o)
  );

  assign valid_o = done;

  // a result strobe only while busy
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result outside busy");
  // no two result strobes back to back
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe too long");
endmodule
`default_nettype wire
